FILE: rtl/ipv4_five_tuple_extractor_macros.svh
// ----------------------------------------------------------------------------
// ipv4_five_tuple_extractor assertion macros
// shared property wrappers for the extractor checks
// ----------------------------------------------------------------------------
`ifndef IPV4_FIVE_TUPLE_EXTRACTOR_MACROS_SVH
`define IPV4_FIVE_TUPLE_EXTRACTOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define FTE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("five tuple extractor check failed");

// next-cycle implication, disabled in reset
`define FTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("five tuple extractor check failed");

`endif

FILE: rtl/ipv4_fte_pkg.sv
// ----------------------------------------------------------------------------
// ipv4_fte_pkg
// constants for the ipv4 five tuple extractor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipv4_fte_pkg;

    localparam int unsigned COUNT_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [COUNT_W-1:0] MIN_HDR_BYTES = 16'd20;
    localparam logic [3:0]         VERSION_V4    = 4'd4;
    localparam logic [3:0]         MIN_IHL       = 4'd5;
    localparam logic [7:0]         PROTO_TCP     = 8'd6;
    localparam logic [7:0]         PROTO_UDP     = 8'd17;

    // fixed header byte positions
    localparam logic [COUNT_W-1:0] POS_VER_IHL  = 16'd0;
    localparam logic [COUNT_W-1:0] POS_LEN_HI   = 16'd2;
    localparam logic [COUNT_W-1:0] POS_LEN_LO   = 16'd3;
    localparam logic [COUNT_W-1:0] POS_PROTO    = 16'd9;
    localparam logic [COUNT_W-1:0] POS_SRC_LO   = 16'd12;
    localparam logic [COUNT_W-1:0] POS_SRC_HI   = 16'd15;
    localparam logic [COUNT_W-1:0] POS_DST_LO   = 16'd16;
    localparam logic [COUNT_W-1:0] POS_DST_HI   = 16'd19;

endpackage

FILE: rtl/ipv4_five_tuple_extractor.sv
// ----------------------------------------------------------------------------
// ipv4_five_tuple_extractor
// streams an ipv4 packet byte by byte and reports its five tuple
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready carry one packet byte per word, with
// i_end_of_packet high on the final byte. Output channel: o_valid / i_ready
// carry one result word per packet (accepted flag, protocol, addresses,
// ports); rejected packets give an all-zero word.
// Every byte only updates the byte counter and captures header fields, so a
// byte is taken every cycle while o_ready is high. The result is registered
// and shows up on o_valid in the cycle after the final byte is accepted.
// Throughput: one byte per cycle while o_ready is high.
// While a result waits in the output register and i_ready is low, o_ready is
// low; the result register is the only thing that can hold bytes back.
// Reset (i_rst_n low, synchronous) clears the byte counter and the output
// valid; the next byte accepted is taken as the first byte of a packet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipv4_five_tuple_extractor_macros.svh"

module ipv4_five_tuple_extractor
    import ipv4_fte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_packet_byte,
    input  logic        i_end_of_packet,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_accepted,
    output logic [7:0]  o_protocol_number,
    output logic [31:0] o_src_addr,
    output logic [31:0] o_dst_addr,
    output logic [15:0] o_src_port,
    output logic [15:0] o_dst_port
);

    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [3:0]         r_header_words, n_header_words;
    logic [3:0]         r_ip_version, n_ip_version;
    logic [15:0]        r_total_length, n_total_length;
    logic [7:0]         r_proto, n_proto;
    logic [31:0]        r_src_addr, n_src_addr;
    logic [31:0]        r_dst_addr, n_dst_addr;
    logic [15:0]        r_src_port, n_src_port;
    logic [15:0]        r_dst_port, n_dst_port;

    logic               r_out_valid;
    logic               r_accepted;
    logic [7:0]         r_out_proto;
    logic [31:0]        r_out_src_addr, r_out_dst_addr;
    logic [15:0]        r_out_src_port, r_out_dst_port;

    logic               in_fire;
    logic               out_fire;
    logic [COUNT_W-1:0] pos;
    logic               in_port_zone;
    logic [COUNT_W-1:0] hdr_bytes;
    logic [COUNT_W-1:0] hdr_plus4;
    logic               ok_base;
    logic               is_transport;
    logic               ok;

    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_out_valid && i_ready;
    assign o_ready  = !r_out_valid || i_ready;
    assign pos      = r_byte_count;

    // hdr is a multiple of four, so the port window is pos/4 == ihl
    assign in_port_zone = (r_header_words >= MIN_IHL) &&
                          (pos[COUNT_W-1:2] == {{(COUNT_W-6){1'b0}}, r_header_words});

    always_comb begin
        n_byte_count   = (pos != COUNT_MAX) ? pos + 16'd1 : pos;
        n_header_words = r_header_words;
        n_ip_version   = r_ip_version;
        n_total_length = r_total_length;
        n_proto        = r_proto;
        n_src_addr     = r_src_addr;
        n_dst_addr     = r_dst_addr;
        n_src_port     = r_src_port;
        n_dst_port     = r_dst_port;
        if (pos == POS_VER_IHL) begin
            n_ip_version   = i_packet_byte[7:4];
            n_header_words = i_packet_byte[3:0];
        end else if (pos == POS_LEN_HI) begin
            n_total_length = {i_packet_byte, r_total_length[7:0]};
        end else if (pos == POS_LEN_LO) begin
            n_total_length = {r_total_length[15:8], i_packet_byte};
        end else if (pos == POS_PROTO) begin
            n_proto = i_packet_byte;
        end else if (pos >= POS_SRC_LO && pos <= POS_SRC_HI) begin
            n_src_addr = {r_src_addr[23:0], i_packet_byte};
        end else if (pos >= POS_DST_LO && pos <= POS_DST_HI) begin
            n_dst_addr = {r_dst_addr[23:0], i_packet_byte};
        end else if (in_port_zone) begin
            if (!pos[1]) begin
                n_src_port = {r_src_port[7:0], i_packet_byte};
            end else begin
                n_dst_port = {r_dst_port[7:0], i_packet_byte};
            end
        end
    end

    // checks run on the state as it stands after this byte
    assign hdr_bytes    = {{(COUNT_W-6){1'b0}}, n_header_words, 2'b00};
    assign hdr_plus4    = hdr_bytes + 16'd4;
    assign ok_base      = (n_byte_count >= MIN_HDR_BYTES) && (n_ip_version == VERSION_V4) &&
                          (n_header_words >= MIN_IHL) && (n_byte_count >= hdr_bytes) &&
                          (n_total_length >= hdr_bytes);
    assign is_transport = (n_proto == PROTO_TCP) || (n_proto == PROTO_UDP);
    assign ok           = ok_base && (!is_transport || (n_byte_count >= hdr_plus4));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
        end else if (in_fire) begin
            r_byte_count <= i_end_of_packet ? '0 : n_byte_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_header_words <= n_header_words;
            r_ip_version   <= n_ip_version;
            r_total_length <= n_total_length;
            r_proto        <= n_proto;
            r_src_addr     <= n_src_addr;
            r_dst_addr     <= n_dst_addr;
            r_src_port     <= n_src_port;
            r_dst_port     <= n_dst_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && i_end_of_packet) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_end_of_packet) begin
            r_accepted     <= ok;
            r_out_proto    <= ok ? n_proto : 8'd0;
            r_out_src_addr <= ok ? n_src_addr : 32'd0;
            r_out_dst_addr <= ok ? n_dst_addr : 32'd0;
            r_out_src_port <= (ok && is_transport) ? n_src_port : 16'd0;
            r_out_dst_port <= (ok && is_transport) ? n_dst_port : 16'd0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_accepted        = r_accepted;
    assign o_protocol_number = r_out_proto;
    assign o_src_addr        = r_out_src_addr;
    assign o_dst_addr        = r_out_dst_addr;
    assign o_src_port        = r_out_src_port;
    assign o_dst_port        = r_out_dst_port;

    `FTE_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, in_fire && i_end_of_packet,
        o_valid)
    `FTE_ASSERT_NEXT(a_count_cleared, i_clk, i_rst_n, in_fire && i_end_of_packet,
        r_byte_count == '0)
    `FTE_ASSERT_IMPL(a_reject_zero, i_clk, i_rst_n, o_valid && !o_accepted,
        o_protocol_number == 8'd0 && o_src_addr == 32'd0 && o_dst_addr == 32'd0 &&
        o_src_port == 16'd0 && o_dst_port == 16'd0)
    `FTE_ASSERT_IMPL(a_other_proto_no_ports, i_clk, i_rst_n,
        o_valid && o_protocol_number != PROTO_TCP && o_protocol_number != PROTO_UDP,
        o_src_port == 16'd0 && o_dst_port == 16'd0)

endmodule
